[rtl/aesp_pkg.sv]
// Package for the escape sequence parser: modes, action codes, sizes.
// No dependencies.
`default_nettype none
package aesp_pkg;
   localparam int ParamSlots = 16;
   localparam int IntermediateLimit = 16;
   localparam int PIdxW = $clog2(ParamSlots);
   localparam int PCntW = $clog2(ParamSlots + 1);
   localparam int ICntW = $clog2(IntermediateLimit + 1);
   localparam logic [30:0] PMax = 31'h7FFF_FFFF;

   typedef enum logic [2:0] {
      M_GROUND, M_ESC, M_ESC_INT, M_CSI_ENTRY, M_CSI_PARAM, M_CSI_INT, M_STRING
   } mode_type;

   typedef enum logic [3:0] {
      A_PRINT, A_LF, A_CR, A_BS, A_TAB, A_BELL, A_CTRL, A_UP, A_DOWN, A_FWD, A_BACK,
      A_POS, A_ED, A_EL, A_SGR, A_DESIG
   } action_type;

   typedef enum logic [1:0] {C_NONE, C_DIGIT, C_SEP, C_CLEAR} pcmd_op_type;

   typedef struct packed {
      pcmd_op_type op;
      logic [3:0] digit;
      logic [PIdxW-1:0] rd_idx;
   } pcmd_type;

   typedef struct packed {
      logic [PCntW-1:0] count;
      logic [30:0] rd_data;
   } pstat_type;

   typedef struct packed {
      logic [3:0] action;
      logic [30:0] arg_one;
      logic [30:0] arg_two;
      logic [15:0] char_code;
      logic last;
   } rsp_type;
endpackage
`default_nettype wire

[rtl/aesp_if.sv]
// Valid/ready channel interface carrying a payload of type T.
// Depends on nothing.
`default_nettype none
interface aesp_if #(parameter type T = logic) (input wire logic clock);
   logic valid;
   logic ready;
   T data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/aesp_datapath.sv]
// Parameter store and accumulator; digit multiply, separator and read port.
// Depends on aesp_pkg.
`default_nettype none
module aesp_datapath (
   input wire logic clock,
   input wire logic reset,
   input wire aesp_pkg::pcmd_type cmd,
   output aesp_pkg::pstat_type stat
);
   import aesp_pkg::*;
   logic [30:0] store_ff [ParamSlots];
   logic [PCntW-1:0] count_ff, count_in;
   logic [30:0] rd_ff;
   logic [PIdxW-1:0] cur;
   logic [30:0] cur_val;
   logic [35:0] prod;
   logic [30:0] acc;

   assign cur = (count_ff == '0) ? '0 : PIdxW'(count_ff - 1'b1);
   assign cur_val = (count_ff == '0) ? 31'd0 : store_ff[cur];
   assign prod = {5'd0, cur_val} * 36'd10 + {32'd0, cmd.digit};
   assign acc = (prod > {5'd0, PMax}) ? PMax : prod[30:0];

   always_comb begin
      count_in = count_ff;
      case (cmd.op)
         C_CLEAR: count_in = '0;
         C_DIGIT: if (count_ff == '0) count_in = PCntW'(1);
         C_SEP: begin
            if (count_ff == '0) count_in = PCntW'(2);
            else if (count_ff < PCntW'(ParamSlots)) count_in = count_ff + 1'b1;
         end
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else count_ff <= count_in;
      case (cmd.op)
         C_DIGIT: store_ff[cur] <= acc;
         C_SEP: begin
            if (count_ff == '0) begin
               store_ff[0] <= 31'd0;
               store_ff[1] <= 31'd0;
            end else if (count_ff < PCntW'(ParamSlots)) begin
               store_ff[PIdxW'(count_ff)] <= 31'd0;
            end
         end
         default: ;
      endcase
      rd_ff <= store_ff[cmd.rd_idx];
   end

   assign stat.count = count_ff;
   assign stat.rd_data = rd_ff;
endmodule
`default_nettype wire

[rtl/aesp_control.sv]
// Parser state machine: decodes units, issues store commands, builds results.
// Depends on aesp_pkg.
`default_nettype none
module aesp_control (
   input wire logic clock,
   input wire logic reset,
   input wire logic in_valid,
   output logic in_ready,
   input wire logic [15:0] in_code,
   output logic out_valid,
   input wire logic out_ready,
   output aesp_pkg::rsp_type out_data,
   output aesp_pkg::pcmd_type cmd,
   input wire aesp_pkg::pstat_type stat
);
   import aesp_pkg::*;
   typedef enum logic [1:0] {S_RUN, S_READ, S_SGR, S_NEL} seq_type;
   mode_type mode_ff, mode_in;
   seq_type seq_ff, seq_in;
   logic [ICntW-1:0] icnt_ff, icnt_in;
   logic [6:0] ifirst_ff, ifirst_in;
   logic [PIdxW-1:0] idx_ff, idx_in;
   logic ovalid_ff, ovalid_in;
   rsp_type odata_ff, odata_in;
   logic [30:0] p0_ff, p0_in, p1;
   logic wait_ff, wait_in;
   logic [7:0] fin_ff, fin_in;
   logic take, space, hi, none, quest, bang, sgr_end;
   logic [15:0] ch;

   assign ch = in_code;
   assign hi = ch[15:8] != 8'd0;
   assign space = !ovalid_ff || out_ready;
   assign none = icnt_ff == '0;
   assign quest = icnt_ff == ICntW'(1) && ifirst_ff == 7'h3F;
   assign bang = icnt_ff == ICntW'(1) && ifirst_ff == 7'h21;
   assign sgr_end = (PCntW'(idx_ff) + 1'b1) >= stat.count;
   assign in_ready = seq_ff == S_RUN && space;
   assign take = in_valid && in_ready;
   assign out_valid = ovalid_ff;
   assign out_data = odata_ff;

   function automatic rsp_type mk(logic [3:0] a, logic [30:0] x, logic [30:0] y,
                                  logic [15:0] c, logic l);
      rsp_type r;
      r.action = a; r.arg_one = x; r.arg_two = y; r.char_code = c; r.last = l;
      return r;
   endfunction

   function automatic logic [30:0] dflt1(logic [30:0] v);
      return (v == 31'd0) ? 31'd1 : v;
   endfunction

   always_comb begin
      mode_in = mode_ff; seq_in = seq_ff; icnt_in = icnt_ff; ifirst_in = ifirst_ff;
      idx_in = idx_ff; p0_in = p0_ff; wait_in = 1'b0; fin_in = fin_ff;
      ovalid_in = ovalid_ff && !out_ready; odata_in = odata_ff;
      cmd.op = C_NONE; cmd.digit = ch[3:0]; cmd.rd_idx = idx_ff;
      p1 = (stat.count > PCntW'(1)) ? stat.rd_data : 31'd0;
      case (seq_ff)
         S_RUN: if (take) begin
            case (mode_ff)
               M_GROUND: begin
                  if (ch == 16'h1B) begin
                     cmd.op = C_CLEAR; icnt_in = '0; ifirst_in = '0; mode_in = M_ESC;
                  end else begin
                     ovalid_in = 1'b1;
                     if (hi || ch >= 16'h20)
                        odata_in = mk(A_PRINT, 31'd0, 31'd0, ch, 1'b1);
                     else if (ch == 16'h0A) odata_in = mk(A_LF, 31'd0, 31'd0, ch, 1'b1);
                     else if (ch == 16'h0D) odata_in = mk(A_CR, 31'd0, 31'd0, ch, 1'b1);
                     else if (ch == 16'h08) odata_in = mk(A_BS, 31'd0, 31'd0, ch, 1'b1);
                     else if (ch == 16'h09) odata_in = mk(A_TAB, 31'd0, 31'd0, ch, 1'b1);
                     else if (ch == 16'h07) odata_in = mk(A_BELL, 31'd0, 31'd0, ch, 1'b1);
                     else odata_in = mk(A_CTRL, 31'd0, 31'd0, ch, 1'b1);
                  end
               end
               M_ESC: begin
                  mode_in = M_GROUND;
                  if (hi) mode_in = M_GROUND;
                  else if (ch == 16'h5B) mode_in = M_CSI_ENTRY;
                  else if (ch >= 16'h28 && ch <= 16'h2F) begin
                     icnt_in = ICntW'(1); ifirst_in = ch[6:0]; mode_in = M_ESC_INT;
                  end else if (ch == 16'h50 || ch == 16'h5D || ch == 16'h58
                               || ch == 16'h5E || ch == 16'h5F) mode_in = M_STRING;
                  else if (ch == 16'h44) begin
                     ovalid_in = 1'b1; odata_in = mk(A_LF, 31'd0, 31'd0, 16'h0A, 1'b1);
                  end else if (ch == 16'h45) begin
                     ovalid_in = 1'b1; odata_in = mk(A_CR, 31'd0, 31'd0, 16'h0D, 1'b0);
                     seq_in = S_NEL;
                  end
               end
               M_ESC_INT: begin
                  mode_in = M_GROUND;
                  if (!hi && ch >= 16'h20 && ch <= 16'h7E) begin
                     if (icnt_ff == ICntW'(1)) begin
                        ovalid_in = 1'b1;
                        case (ifirst_ff)
                           7'h28: odata_in = mk(A_DESIG, 31'd0, 31'd0, ch, 1'b1);
                           7'h29, 7'h2D: odata_in = mk(A_DESIG, 31'd1, 31'd0, ch, 1'b1);
                           7'h2A, 7'h2E: odata_in = mk(A_DESIG, 31'd2, 31'd0, ch, 1'b1);
                           7'h2B, 7'h2F: odata_in = mk(A_DESIG, 31'd3, 31'd0, ch, 1'b1);
                           default: ovalid_in = ovalid_ff && !out_ready;
                        endcase
                     end
                  end
               end
               M_CSI_ENTRY, M_CSI_PARAM, M_CSI_INT: begin
                  mode_in = M_GROUND;
                  if (!hi && ch >= 16'h30 && ch <= 16'h39 && mode_ff != M_CSI_INT) begin
                     cmd.op = C_DIGIT; mode_in = M_CSI_PARAM;
                  end else if (!hi && ch == 16'h3B && mode_ff != M_CSI_INT) begin
                     cmd.op = C_SEP; mode_in = M_CSI_PARAM;
                  end else if (!hi && ((ch >= 16'h20 && ch <= 16'h2F)
                               || (mode_ff == M_CSI_ENTRY && ch >= 16'h3C && ch <= 16'h3F)))
                  begin
                     mode_in = M_CSI_INT;
                     if (icnt_ff < ICntW'(IntermediateLimit)) begin
                        icnt_in = icnt_ff + 1'b1;
                        if (none) ifirst_in = ch[6:0];
                     end
                  end else if (!hi && ch >= 16'h40 && ch <= 16'h7E) begin
                     if (none || quest || bang) begin
                        fin_in = ch[7:0]; idx_in = '0;
                        cmd.rd_idx = '0; seq_in = S_READ; wait_in = 1'b0;
                     end
                  end
               end
               default: mode_in = M_GROUND;
            endcase
         end
         S_NEL: if (space) begin
            ovalid_in = 1'b1; odata_in = mk(A_LF, 31'd0, 31'd0, 16'h0A, 1'b1);
            seq_in = S_RUN;
         end
         S_READ: begin
            // rd_ff holds param 0; fetch param 1
            wait_in = 1'b1;
            cmd.rd_idx = PIdxW'(1);
            if (!wait_ff) begin
               p0_in = (stat.count != '0) ? stat.rd_data : 31'd0;
            end else if (space) begin
               seq_in = S_RUN; ovalid_in = 1'b1; wait_in = 1'b0;
               case (fin_ff)
                  8'h41, 8'h42, 8'h43, 8'h44, 8'h48, 8'h66: begin
                     if (!none) ovalid_in = ovalid_ff && !out_ready;
                     case (fin_ff)
                        8'h41: odata_in = mk(A_UP, dflt1(p0_ff), 31'd0, 16'd0, 1'b1);
                        8'h42: odata_in = mk(A_DOWN, dflt1(p0_ff), 31'd0, 16'd0, 1'b1);
                        8'h43: odata_in = mk(A_FWD, dflt1(p0_ff), 31'd0, 16'd0, 1'b1);
                        8'h44: odata_in = mk(A_BACK, dflt1(p0_ff), 31'd0, 16'd0, 1'b1);
                        default:
                           odata_in = mk(A_POS, dflt1(p0_ff), dflt1(p1), 16'd0, 1'b1);
                     endcase
                  end
                  8'h4A, 8'h4B: begin
                     if (bang) ovalid_in = ovalid_ff && !out_ready;
                     odata_in = mk(fin_ff == 8'h4A ? A_ED : A_EL, p0_ff, 31'd0, 16'd0, 1'b1);
                  end
                  8'h6D: begin
                     odata_in = mk(A_SGR, p0_ff, 31'd0, 16'd0, stat.count <= PCntW'(1));
                     if (stat.count > PCntW'(1)) begin
                        seq_in = S_SGR; idx_in = PIdxW'(1);
                        cmd.rd_idx = PIdxW'(1);
                     end
                  end
                  default: ovalid_in = ovalid_ff && !out_ready;
               endcase
            end
         end
         S_SGR: begin
            cmd.rd_idx = idx_ff;
            if (space) begin
               ovalid_in = 1'b1;
               odata_in = mk(A_SGR, stat.rd_data, 31'd0, 16'd0, sgr_end);
               if (sgr_end) seq_in = S_RUN;
               else begin
                  idx_in = idx_ff + 1'b1; cmd.rd_idx = idx_ff + 1'b1;
               end
            end
         end
         default: seq_in = S_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_GROUND; seq_ff <= S_RUN; icnt_ff <= '0; ifirst_ff <= '0;
         ovalid_ff <= 1'b0; wait_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in; seq_ff <= seq_in; icnt_ff <= icnt_in; ifirst_ff <= ifirst_in;
         ovalid_ff <= ovalid_in; wait_ff <= wait_in;
      end
      idx_ff <= idx_in; p0_ff <= p0_in; fin_ff <= fin_in; odata_ff <= odata_in;
   end
endmodule
`default_nettype wire

[rtl/ansi_escape_sequence_parser_unit.sv]
// Top level of the escape sequence parser: controller plus parameter store.
// Units are accepted back to back while the output register has space; a CSI final
// stalls input in S_READ, then S_SGR for extra SGR params: single store read port.
// ESC E stalls in S_NEL. Results leave an output register; CSI ones after S_READ.
// Synchronous reset returns to ground with no parameters; store holds garbage.
// Depends on aesp_pkg, aesp_if, aesp_control, aesp_datapath.
`default_nettype none
module ansi_escape_sequence_parser_unit (
   input wire logic clock,
   input wire logic reset,
   aesp_if.sink req,
   aesp_if.source rsp
);
   import aesp_pkg::*;
   pcmd_type cmd;
   pstat_type stat;

   aesp_control u_ctrl (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_ready(req.ready), .in_code(req.data),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data),
      .cmd(cmd), .stat(stat)
   );

   aesp_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat)
   );
endmodule
`default_nettype wire

[tb/sv/ansi_escape_sequence_parser_unit_tb.sv]
// Testbench for ansi_escape_sequence_parser_unit: directed and random terminal streams
// through a behavioural parser model, results checked in order. Needs aesp_pkg, aesp_if.
`timescale 1ns / 100ps
`default_nettype none
module ansi_escape_sequence_parser_unit_tb;
   import aesp_pkg::*;

   localparam logic [15:0] Esc = 16'h1B;

   logic clock;
   logic reset;

   aesp_if #(.T(logic [15:0])) req (.clock(clock));
   aesp_if #(.T(rsp_type)) rsp (.clock(clock));

   ansi_escape_sequence_parser_unit dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source)
   );

   logic [15:0] unit_queue[$];
   rsp_type action_queue[$];
   int errors = 0;
   int rx_count = 0;
   bit stim_done = 0;

   // parser model state
   mode_type model_mode;
   logic [30:0] pstore[ParamSlots];
   int pcount, icount;
   logic [6:0] first_int;

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("ansi_escape_sequence_parser_unit_tb: FAIL");
      $finish;
   end

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic rsp_type mk(input action_type a, input logic [30:0] a1,
                                  input logic [30:0] a2, input logic [15:0] cc);
      rsp_type r;
      r.action = a; r.arg_one = a1; r.arg_two = a2; r.char_code = cc; r.last = 0;
      return r;
   endfunction

   function automatic logic [30:0] param_or(input int idx, input logic [30:0] dflt);
      if (idx < pcount) begin
         if (pstore[idx] == 0 && dflt != 0) return dflt;
         return pstore[idx];
      end
      return dflt;
   endfunction

   task automatic add_digit(input logic [15:0] ch);
      logic [63:0] v;
      if (pcount == 0) begin
         pstore[0] = 0; pcount = 1;
      end
      v = 64'(pstore[pcount-1]) * 10 + 64'(ch - 16'h30);
      if (v > 64'(PMax)) v = 64'(PMax);
      pstore[pcount-1] = v[30:0];
   endtask

   task automatic add_sep();
      if (pcount < ParamSlots) begin
         if (pcount == 0) begin
            pstore[0] = 0; pcount = 1;
         end
         pstore[pcount] = 0;
         pcount++;
      end
   endtask

   task automatic collect(input logic [15:0] ch);
      if (icount < IntermediateLimit) begin
         if (icount == 0) first_int = ch[6:0];
         icount++;
      end
   endtask

   task automatic csi_final(input logic [15:0] ch, inout rsp_type outq[$]);
      bit none, quest, bang;
      none = icount == 0;
      quest = icount == 1 && first_int == 7'h3F;
      bang = icount == 1 && first_int == 7'h21;
      if (!none && !quest && !bang) return;
      case (ch)
         "A": if (none)
            outq.insert(outq.size(), mk(A_UP, param_or(0, 31'd1), 31'd0, 16'd0));
         "B": if (none)
            outq.insert(outq.size(), mk(A_DOWN, param_or(0, 31'd1), 31'd0, 16'd0));
         "C": if (none)
            outq.insert(outq.size(), mk(A_FWD, param_or(0, 31'd1), 31'd0, 16'd0));
         "D": if (none)
            outq.insert(outq.size(), mk(A_BACK, param_or(0, 31'd1), 31'd0, 16'd0));
         "H", "f": if (none)
            outq.insert(outq.size(),
                        mk(A_POS, param_or(0, 31'd1), param_or(1, 31'd1), 16'd0));
         "J": if (none || quest)
            outq.insert(outq.size(), mk(A_ED, param_or(0, 31'd0), 31'd0, 16'd0));
         "K": if (none || quest)
            outq.insert(outq.size(), mk(A_EL, param_or(0, 31'd0), 31'd0, 16'd0));
         "m": begin
            if (pcount == 0) outq.insert(outq.size(), mk(A_SGR, 31'd0, 31'd0, 16'd0));
            else for (int i = 0; i < pcount; i++)
               outq.insert(outq.size(), mk(A_SGR, pstore[i], 31'd0, 16'd0));
         end
         default: ;
      endcase
   endtask

   task automatic esc_final(input logic [15:0] ch, inout rsp_type outq[$]);
      int slot;
      slot = -1;
      if (icount == 1) begin
         case (first_int)
            "(": slot = 0;
            ")", "-": slot = 1;
            "*", ".": slot = 2;
            "+", "/": slot = 3;
            default: ;
         endcase
         if (slot >= 0) begin
            outq.insert(outq.size(), mk(A_DESIG, 31'(slot), 31'd0, ch));
            return;
         end
      end
      if (icount == 0) begin
         if (ch == "D") outq.insert(outq.size(), mk(A_LF, 31'd0, 31'd0, 16'h0A));
         else if (ch == "E") begin
            outq.insert(outq.size(), mk(A_CR, 31'd0, 31'd0, 16'h0D));
            outq.insert(outq.size(), mk(A_LF, 31'd0, 31'd0, 16'h0A));
         end
      end
   endtask

   task automatic predict_actions(input logic [15:0] ch);
      rsp_type outq[$];
      case (model_mode)
         M_GROUND: begin
            if (ch >= 16'h20 && ch <= 16'h7F)
               outq.insert(outq.size(), mk(A_PRINT, 31'd0, 31'd0, ch));
            else if (ch == Esc) begin
               pcount = 0; icount = 0; first_int = 0; model_mode = M_ESC;
            end
            else if (ch == 16'h0A) outq.insert(outq.size(), mk(A_LF, 31'd0, 31'd0, ch));
            else if (ch == 16'h0D) outq.insert(outq.size(), mk(A_CR, 31'd0, 31'd0, ch));
            else if (ch == 16'h08) outq.insert(outq.size(), mk(A_BS, 31'd0, 31'd0, ch));
            else if (ch == 16'h09) outq.insert(outq.size(), mk(A_TAB, 31'd0, 31'd0, ch));
            else if (ch == 16'h07) outq.insert(outq.size(), mk(A_BELL, 31'd0, 31'd0, ch));
            else if (ch < 16'h20) outq.insert(outq.size(), mk(A_CTRL, 31'd0, 31'd0, ch));
            else outq.insert(outq.size(), mk(A_PRINT, 31'd0, 31'd0, ch));
         end
         M_ESC: begin
            if (ch == "[") model_mode = M_CSI_ENTRY;
            else if (ch >= 16'h28 && ch <= 16'h2F) begin
               collect(ch); model_mode = M_ESC_INT;
            end
            else if (ch == "P" || ch == "]" || ch == "X" || ch == "^" || ch == "_")
               model_mode = M_STRING;
            else if (ch >= 16'h40 && ch <= 16'h5F) begin
               esc_final(ch, outq); model_mode = M_GROUND;
            end
            else model_mode = M_GROUND;
         end
         M_ESC_INT: begin
            if (ch >= 16'h20 && ch <= 16'h7E) esc_final(ch, outq);
            model_mode = M_GROUND;
         end
         M_CSI_ENTRY, M_CSI_PARAM: begin
            if (ch >= "0" && ch <= "9") begin
               add_digit(ch); model_mode = M_CSI_PARAM;
            end
            else if (ch == ";") begin
               add_sep(); model_mode = M_CSI_PARAM;
            end
            else if (ch >= 16'h20 && ch <= 16'h2F) begin
               collect(ch); model_mode = M_CSI_INT;
            end
            else if (model_mode == M_CSI_ENTRY && ch >= "<" && ch <= "?") begin
               collect(ch); model_mode = M_CSI_INT;
            end
            else if (ch >= 16'h40 && ch <= 16'h7E) begin
               csi_final(ch, outq); model_mode = M_GROUND;
            end
            else model_mode = M_GROUND;
         end
         M_CSI_INT: begin
            if (ch >= 16'h20 && ch <= 16'h2F) collect(ch);
            else if (ch >= 16'h40 && ch <= 16'h7E) begin
               csi_final(ch, outq); model_mode = M_GROUND;
            end
            else model_mode = M_GROUND;
         end
         default: model_mode = M_GROUND;
      endcase
      if (outq.size() > 0) outq[outq.size()-1].last = 1;
      foreach (outq[i]) action_queue.insert(action_queue.size(), outq[i]);
   endtask

   // stimulus builders
   task automatic enq(input logic [15:0] u);
      unit_queue.insert(unit_queue.size(), u);
   endtask

   task automatic put_str(input string s);
      for (int i = 0; i < s.len(); i++) enq(16'(s[i]));
   endtask

   task automatic put_csi();
      int np, k;
      string finals;
      finals = "ABCDHfJKmmm";
      enq(Esc);
      enq(16'("["));
      k = $urandom_range(0, 9);
      if (k == 0) enq(16'("?"));
      else if (k == 1) enq(16'("!"));
      np = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 19) : $urandom_range(0, 4);
      for (int p = 0; p < np; p++) begin
         if (p > 0) enq(16'(";"));
         k = $urandom_range(0, 3);
         if (k == 1) enq(16'("0" + $urandom_range(0, 9)));
         else if (k == 2) put_str($sformatf("%0d", $urandom_range(0, 300)));
         else if (k == 3) put_str("9999999999");
      end
      k = $urandom_range(0, 11);
      if (k == 0) enq(16'($urandom_range(16'h20, 16'h2F)));
      else if (k == 1) repeat ($urandom_range(2, 18)) enq(16'(" "));
      k = $urandom_range(0, 9);
      if (k == 0) enq(16'($urandom_range(16'h40, 16'h7E)));
      else if (k == 1) enq(16'($urandom));
      else enq(16'(finals[$urandom_range(0, finals.len()-1)]));
   endtask

   task automatic put_esc();
      int k;
      enq(Esc);
      k = $urandom_range(0, 5);
      if (k < 3) begin
         enq(16'($urandom_range(16'h28, 16'h2F)));
         enq(16'($urandom_range(16'h20, 16'h7F)));
      end
      else if (k == 3) begin
         enq(16'($urandom_range(0, 1) ? "E" : "D"));
      end
      else if (k == 4) begin
         enq(16'($urandom_range(0, 1) ? "P" : "]"));
         enq(16'($urandom));
      end
      else enq(16'($urandom_range(16'h20, 16'h7F)));
   endtask

   initial begin
      int k;
      reset = 1;
      // directed
      enq(16'h20); enq(16'h7F);
      enq(16'hFFFF); enq(16'h0080);
      enq(16'h0A); enq(16'h0D);
      enq(16'h08); enq(16'h09);
      enq(16'h07); enq(16'h00);
      enq(Esc); put_str("[5A");
      enq(Esc); put_str("[;7H");
      enq(Esc); put_str("[99999999999;0m");
      enq(Esc); put_str("[?2J");
      enq(Esc); put_str("[m");
      enq(Esc); put_str("[;;;;;;;;;;;;;;;;;;1m");
      enq(Esc); put_str("(B");
      enq(Esc); put_str("E");
      enq(Esc); put_str("Dx");
      enq(Esc); put_str("Pq");
      enq(Esc); put_str("[1"); enq(Esc); put_str("[2K");
      // random
      while (unit_queue.size() < 260) begin
         k = $urandom_range(0, 9);
         if (k < 4) put_csi();
         else if (k < 6) put_esc();
         else if (k < 8) enq(16'($urandom_range(16'h20, 16'h7E)));
         else if (k == 8) enq(16'($urandom_range(0, 16'h1F)));
         else enq(16'($urandom));
      end
      stim_done = 1;
      repeat (12) @(posedge clock);
      reset <= 0;
   end

   // sender
   int tx_gap = 0;
   int tx_count = 0;
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req.data <= 16'd0;
         model_mode = M_GROUND; pcount = 0; icount = 0; first_int = 0;
      end else begin
         if (req.valid && req.ready) begin
            predict_actions(req.data);
            tx_count++;
            tx_gap = ((tx_count / 50) % 3 == 1) ? 0 : $urandom_range(0, 7);
         end
         if ((req.valid && !req.ready)) ;
         else if (tx_gap > 0) begin
            req.valid <= 0;
            tx_gap--;
         end else if (unit_queue.size() > 0) begin
            req.valid <= 1;
            req.data <= unit_queue.pop_front();
         end else req.valid <= 0;
      end
   end

   // receiver
   int rx_stall = 0;
   int hold_left = 0;
   bit hold_done = 0;
   always @(posedge clock) begin
      rsp_type want;
      if (reset) rsp.ready <= 1'b0;
      else begin
         if (rsp.valid && rsp.ready) begin
            rx_count++;
            if (action_queue.size() == 0)
               report("unexpected result", 32'(rsp.data.action), 32'd0);
            else begin
               want = action_queue.pop_front();
               if (rsp.data.action != want.action)
                  report("action", 32'(rsp.data.action), 32'(want.action));
               if (rsp.data.arg_one != want.arg_one)
                  report("arg_one", 32'(rsp.data.arg_one), 32'(want.arg_one));
               if (rsp.data.arg_two != want.arg_two)
                  report("arg_two", 32'(rsp.data.arg_two), 32'(want.arg_two));
               if (rsp.data.char_code != want.char_code)
                  report("char_code", 32'(rsp.data.char_code), 32'(want.char_code));
               if (rsp.data.last != want.last)
                  report("last", 32'(rsp.data.last), 32'(want.last));
            end
            rx_stall = ((rx_count / 40) % 3 == 2) ? 0 : $urandom_range(0, 7);
            if (!hold_done && rx_count == 30) begin
               hold_left = 300; hold_done = 1;
            end
         end
         if (hold_left > 0) begin
            rsp.ready <= 0;
            hold_left--;
         end else if (rx_stall > 0) begin
            rsp.ready <= 0;
            rx_stall--;
         end else rsp.ready <= 1;
      end
   end

   initial begin
      wait (stim_done && !reset);
      @(posedge clock);
      while (unit_queue.size() > 0 || req.valid || action_queue.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (action_queue.size() > 0)
         report("missing results", 32'(action_queue.size()), 32'd0);
      if (errors == 0) $display("ansi_escape_sequence_parser_unit_tb: PASS");
      else $display("ansi_escape_sequence_parser_unit_tb: FAIL");
      $finish;
   end
endmodule
`default_nettype wire
